[hdl/rpk_pkg.sv]
// Shared types and constants for the RSA public key DER encoder.
package rpk_pkg;

	// Size limits
	localparam int MAX_MODULUS_BYTES  = 512;
	localparam int MAX_EXPONENT_BYTES = 8;

	// Register widths and effective length widths
	localparam int MOD_REG_W = 10;
	localparam int EXP_REG_W = 4;
	localparam int EXP_VAL_W = 64;
	localparam int MOD_EFF_W = 11;
	localparam int CFG_IDX_W = 2;

	// Reset values of the registers
	localparam logic [MOD_REG_W-1:0] MOD_LEN_RESET = MOD_REG_W'(256);
	localparam logic [EXP_REG_W-1:0] EXP_LEN_RESET = EXP_REG_W'(3);
	localparam logic [EXP_VAL_W-1:0] EXP_VAL_RESET = EXP_VAL_W'(65537);

	// Command queue depth
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// DER encoding bytes
	localparam logic [7:0] DER_TAG_SEQUENCE = 8'h30;
	localparam logic [7:0] DER_TAG_INTEGER  = 8'h02;
	localparam logic [7:0] DER_LEN_LONG2    = 8'h82;
	localparam logic [7:0] DER_ZERO_PAD     = 8'h00;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODULUS_LENGTH  = 2'd0,
		REG_EXPONENT_LENGTH = 2'd1,
		REG_EXPONENT_VALUE  = 2'd2
	} reg_index_t;

	// One classified modulus byte
	typedef struct packed {
		logic [7:0] data;
		logic       first;
		logic       last;
	} cmd_t;

	// Effective key settings seen by the back end
	typedef struct packed {
		logic [MOD_EFF_W-1:0] mod_len;
		logic [EXP_REG_W-1:0] exp_len;
		logic [EXP_VAL_W-1:0] exp_value;
	} key_cfg_t;

endpackage

[hdl/rsa_public_key_der_encoder.sv]
// Top level of the RSA public key DER encoder.
// Modulus bytes go in one word per cycle while in_ready is high, most significant first;
// the block emits the DER SEQUENCE { INTEGER modulus, INTEGER exponent } one byte per
// cycle on the output channel while a word is queued and out_ready allows. The front end
// takes a word in any cycle in which the 4-entry command queue has room; the back end
// drains it, each modulus word giving 1 output byte in the body of a key, 9 or 10 for the
// first word (header and optional zero pad) and 3 to 11 more for the last word (exponent
// INTEGER). The output byte rate of the back end sets the sustained throughput. Registers
// are written by the user through cfg_we / cfg_index / cfg_data (0 modulus_length, 1
// exponent_length, 2 exponent_value) only while no output is pending; it is not enforced.
module rsa_public_key_der_encoder import rpk_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [EXP_VAL_W-1:0] cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           modulus_byte,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           out_byte,
	output logic                 run_last,
	output logic                 key_done
);

	logic     q_full;
	logic     q_empty;
	logic     q_push;
	logic     q_pop;
	cmd_t     push_cmd;
	cmd_t     head_cmd;
	key_cfg_t key_cfg;

	rpk_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.modulus_byte (modulus_byte),
		.q_full       (q_full),
		.push         (q_push),
		.push_cmd     (push_cmd),
		.key_cfg      (key_cfg)
	);

	rpk_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.head     (head_cmd),
		.empty    (q_empty)
	);

	rpk_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_cfg   (key_cfg),
		.head      (head_cmd),
		.empty     (q_empty),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.run_last  (run_last),
		.key_done  (key_done)
	);

endmodule

[hdl/rpk_front.sv]
// Front end: configuration registers and classification of modulus bytes.
module rpk_front import rpk_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [EXP_VAL_W-1:0] cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           modulus_byte,
	input  logic                 q_full,
	output logic                 push,
	output cmd_t                 push_cmd,
	output key_cfg_t             key_cfg
);

	logic [MOD_REG_W-1:0] mod_len_q;
	logic [EXP_REG_W-1:0] exp_len_q;
	logic [EXP_VAL_W-1:0] exp_val_q;
	logic [MOD_REG_W-1:0] bytes_seen_q;
	logic [MOD_EFF_W-1:0] eff_mod_len;
	logic [EXP_REG_W-1:0] eff_exp_len;
	logic                 is_last;

	// Clamp lengths to their legal ranges
	always_comb begin
		if (mod_len_q == '0) begin
			eff_mod_len = MOD_EFF_W'(1);
		end else if (MOD_EFF_W'(mod_len_q) > MOD_EFF_W'(MAX_MODULUS_BYTES)) begin
			eff_mod_len = MOD_EFF_W'(MAX_MODULUS_BYTES);
		end else begin
			eff_mod_len = MOD_EFF_W'(mod_len_q);
		end
		if (exp_len_q == '0) begin
			eff_exp_len = EXP_REG_W'(1);
		end else if (exp_len_q > EXP_REG_W'(MAX_EXPONENT_BYTES)) begin
			eff_exp_len = EXP_REG_W'(MAX_EXPONENT_BYTES);
		end else begin
			eff_exp_len = exp_len_q;
		end
	end

	assign key_cfg = '{mod_len: eff_mod_len, exp_len: eff_exp_len, exp_value: exp_val_q};

	// Classify the incoming word
	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;
	assign is_last  = (MOD_EFF_W'(bytes_seen_q) + MOD_EFF_W'(1)) >= eff_mod_len;
	assign push_cmd = '{data: modulus_byte, first: (bytes_seen_q == '0), last: is_last};

	// Hold configuration and advance the byte count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_len_q    <= MOD_LEN_RESET;
			exp_len_q    <= EXP_LEN_RESET;
			exp_val_q    <= EXP_VAL_RESET;
			bytes_seen_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (reg_index_t'(cfg_index))
					REG_MODULUS_LENGTH:  mod_len_q <= cfg_data[MOD_REG_W-1:0];
					REG_EXPONENT_LENGTH: exp_len_q <= cfg_data[EXP_REG_W-1:0];
					REG_EXPONENT_VALUE:  exp_val_q <= cfg_data;
					default: ;
				endcase
			end
			if (push) begin
				bytes_seen_q <= is_last ? '0 : bytes_seen_q + MOD_REG_W'(1);
			end
		end
	end

endmodule

[hdl/rpk_queue.sv]
// Short command queue between the front and back ends.
module rpk_queue import rpk_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t head,
	output logic empty
);

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = slot_q[rd_ptr_q];

	// Store pushed words
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue popped while empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count overflow");

endmodule

[hdl/rpk_back.sv]
// Back end: walks each queued word through its DER output bytes.
module rpk_back import rpk_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  key_cfg_t   key_cfg,
	input  cmd_t       head,
	input  logic       empty,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       key_done
);

	typedef enum logic [3:0] {
		PH_SEQ_TAG,
		PH_SEQ_LONG,
		PH_SEQ_LEN_HI,
		PH_SEQ_LEN_LO,
		PH_MOD_TAG,
		PH_MOD_LONG,
		PH_MOD_LEN_HI,
		PH_MOD_LEN_LO,
		PH_MOD_PAD,
		PH_MOD_DATA,
		PH_EXP_TAG,
		PH_EXP_LEN,
		PH_EXP_PAD,
		PH_EXP_DATA
	} phase_t;

	phase_t         phase_q;
	logic           started_q;
	logic [2:0]     exp_idx_q;
	logic           out_valid_q;
	logic [7:0]     out_byte_q;
	logic           run_last_q;
	logic           key_done_q;

	phase_t         cur_phase;
	phase_t         nxt_phase;
	logic [2:0]     nxt_exp_idx;
	logic [7:0]     cur_byte;
	logic           fin;
	logic           emit;
	logic [2:0]     top_sel;
	logic [2:0]     exp_sel;
	logic           exp_pad;
	logic           mod_pad;
	logic [MOD_EFF_W-1:0] mod_int_len;
	logic [EXP_REG_W-1:0] exp_int_len;
	logic [15:0]    seq_len;

	// Length fields of the encoding
	assign top_sel     = 3'(key_cfg.exp_len - EXP_REG_W'(1));
	assign exp_sel     = top_sel - exp_idx_q;
	assign exp_pad     = key_cfg.exp_value[{top_sel, 3'b111}];
	assign mod_pad     = head.data[7];
	assign mod_int_len = key_cfg.mod_len + MOD_EFF_W'(mod_pad);
	assign exp_int_len = key_cfg.exp_len + EXP_REG_W'(exp_pad);
	assign seq_len     = 16'(mod_int_len) + 16'(exp_int_len) + 16'd6;

	assign cur_phase = started_q ? phase_q : (head.first ? PH_SEQ_TAG : PH_MOD_DATA);

	// Select the byte and the following phase
	always_comb begin
		cur_byte    = DER_ZERO_PAD;
		nxt_phase   = cur_phase;
		nxt_exp_idx = exp_idx_q;
		fin         = 1'b0;
		unique case (cur_phase)
			PH_SEQ_TAG: begin
				cur_byte  = DER_TAG_SEQUENCE;
				nxt_phase = PH_SEQ_LONG;
			end
			PH_SEQ_LONG: begin
				cur_byte  = DER_LEN_LONG2;
				nxt_phase = PH_SEQ_LEN_HI;
			end
			PH_SEQ_LEN_HI: begin
				cur_byte  = seq_len[15:8];
				nxt_phase = PH_SEQ_LEN_LO;
			end
			PH_SEQ_LEN_LO: begin
				cur_byte  = seq_len[7:0];
				nxt_phase = PH_MOD_TAG;
			end
			PH_MOD_TAG: begin
				cur_byte  = DER_TAG_INTEGER;
				nxt_phase = PH_MOD_LONG;
			end
			PH_MOD_LONG: begin
				cur_byte  = DER_LEN_LONG2;
				nxt_phase = PH_MOD_LEN_HI;
			end
			PH_MOD_LEN_HI: begin
				cur_byte  = 8'(mod_int_len[MOD_EFF_W-1:8]);
				nxt_phase = PH_MOD_LEN_LO;
			end
			PH_MOD_LEN_LO: begin
				cur_byte  = mod_int_len[7:0];
				nxt_phase = mod_pad ? PH_MOD_PAD : PH_MOD_DATA;
			end
			PH_MOD_PAD: begin
				cur_byte  = DER_ZERO_PAD;
				nxt_phase = PH_MOD_DATA;
			end
			PH_MOD_DATA: begin
				cur_byte  = head.data;
				nxt_phase = PH_EXP_TAG;
				fin       = !head.last;
			end
			PH_EXP_TAG: begin
				cur_byte  = DER_TAG_INTEGER;
				nxt_phase = PH_EXP_LEN;
			end
			PH_EXP_LEN: begin
				cur_byte    = 8'(exp_int_len);
				nxt_phase   = exp_pad ? PH_EXP_PAD : PH_EXP_DATA;
				nxt_exp_idx = '0;
			end
			PH_EXP_PAD: begin
				cur_byte    = DER_ZERO_PAD;
				nxt_phase   = PH_EXP_DATA;
				nxt_exp_idx = '0;
			end
			PH_EXP_DATA: begin
				cur_byte    = key_cfg.exp_value[{exp_sel, 3'b000} +: 8];
				nxt_phase   = PH_EXP_DATA;
				nxt_exp_idx = exp_idx_q + 3'd1;
				fin         = (exp_idx_q == top_sel);
			end
			default: ;
		endcase
	end

	assign emit = !empty && (!out_valid_q || out_ready);
	assign pop  = emit && fin;

	// Advance the sequence and hold the output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SEQ_TAG;
			started_q   <= 1'b0;
			exp_idx_q   <= '0;
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
			run_last_q  <= 1'b0;
			key_done_q  <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
				out_byte_q  <= cur_byte;
				run_last_q  <= fin;
				key_done_q  <= fin && (cur_phase == PH_EXP_DATA);
				started_q   <= !fin;
				phase_q     <= nxt_phase;
				exp_idx_q   <= nxt_exp_idx;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign run_last  = run_last_q;
	assign key_done  = key_done_q;

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && key_done_q |-> run_last_q) else $error("key_done without run_last");

	a_exp_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		started_q && phase_q == PH_EXP_DATA |-> exp_idx_q <= top_sel)
		else $error("exponent index past its length");

endmodule

[verif/tb_rsa_public_key_der_encoder.sv]
// Testbench for the RSA public key DER encoder: directed and random keys, checked word by word.
`timescale 1ns / 100ps

import rpk_pkg::*;

// Predict the DER byte stream of each key and check output words against it
class der_scoreboard;
	typedef struct packed {
		logic [7:0] data;
		logic       run_last;
		logic       key_done;
	} der_word_t;

	der_word_t            der_q[$];
	logic [7:0]           burst_q[$];
	logic [MOD_REG_W-1:0] mod_len_reg;
	logic [EXP_REG_W-1:0] exp_len_reg;
	logic [EXP_VAL_W-1:0] exp_val_reg;
	logic [MOD_REG_W-1:0] bytes_seen;
	int                   errors;
	int                   words_in;
	int                   words_out;
	int                   keys;

	function new();
		mod_len_reg = MOD_LEN_RESET;
		exp_len_reg = EXP_LEN_RESET;
		exp_val_reg = EXP_VAL_RESET;
		bytes_seen  = '0;
		errors      = 0;
		words_in    = 0;
		words_out   = 0;
		keys        = 0;
	endfunction

	// Mirror a register write; unknown indexes are dropped
	function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [EXP_VAL_W-1:0] data);
		case (idx)
			REG_MODULUS_LENGTH:  mod_len_reg = data[MOD_REG_W-1:0];
			REG_EXPONENT_LENGTH: exp_len_reg = data[EXP_REG_W-1:0];
			REG_EXPONENT_VALUE:  exp_val_reg = data;
			default: ;
		endcase
	endfunction

	function int unsigned mod_len_eff();
		int unsigned n;
		n = mod_len_reg;
		if (n < 1) n = 1;
		if (n > MAX_MODULUS_BYTES) n = MAX_MODULUS_BYTES;
		return n;
	endfunction

	function int unsigned exp_len_eff();
		int unsigned n;
		n = exp_len_reg;
		if (n < 1) n = 1;
		if (n > MAX_EXPONENT_BYTES) n = MAX_EXPONENT_BYTES;
		return n;
	endfunction

	// Exponent byte i of n, most significant first
	function logic [7:0] exp_byte(input int unsigned n, input int unsigned i);
		int unsigned sh;
		sh = 8 * ((n - 1 - i) & 7);
		return 8'(exp_val_reg >> sh);
	endfunction

	function int pending();
		return der_q.size();
	endfunction

	// Add one byte to the burst being built
	function void add_byte(input logic [7:0] b);
		burst_q = {burst_q, b};
	endfunction

	// Add one expected word at the tail of the queue
	function void add_word(input der_word_t w);
		der_q = {der_q, w};
	endfunction

	// Expand one accepted modulus word into the DER words it causes
	function void note_word(input logic [7:0] b);
		logic [7:0]  top;
		logic [15:0] seq_len;
		logic        exp_pad;
		logic        key_end;
		int unsigned mlen, elen, ml, el, seen;
		der_word_t   w;
		burst_q.delete();
		mlen    = mod_len_eff();
		elen    = exp_len_eff();
		top     = exp_byte(elen, 0);
		exp_pad = top[7];
		seen    = bytes_seen;
		key_end = (seen + 1) >= mlen;

		// first word of a key: SEQUENCE header, modulus INTEGER header, optional pad
		if (bytes_seen == 0) begin
			ml      = mlen + b[7];
			el      = elen + exp_pad;
			seq_len = 16'(4 + ml + 2 + el);
			add_byte(DER_TAG_SEQUENCE);
			add_byte(DER_LEN_LONG2);
			add_byte(seq_len[15:8]);
			add_byte(seq_len[7:0]);
			add_byte(DER_TAG_INTEGER);
			add_byte(DER_LEN_LONG2);
			add_byte(8'(ml >> 8));
			add_byte(8'(ml));
			if (b[7]) add_byte(DER_ZERO_PAD);
		end
		add_byte(b);

		// last word of a key: append the exponent INTEGER and restart the count
		if (key_end) begin
			add_byte(DER_TAG_INTEGER);
			add_byte(8'(elen + exp_pad));
			if (exp_pad) add_byte(DER_ZERO_PAD);
			for (int i = 0; i < elen; i++) add_byte(exp_byte(elen, i));
			bytes_seen = '0;
		end else begin
			bytes_seen = bytes_seen + 1'b1;
		end

		foreach (burst_q[i]) begin
			w.data     = burst_q[i];
			w.run_last = (i == burst_q.size() - 1);
			w.key_done = key_end && w.run_last;
			add_word(w);
		end
		words_in++;
	endfunction

	task report(input string msg);
		errors++;
		if (errors <= 30) $display("[%0t] mismatch: %s", $time, msg);
	endtask

	// Compare one output word with the oldest expected word
	task check_word(input logic [7:0] data, input logic rl, input logic kd);
		der_word_t w;
		words_out++;
		if (der_q.size() == 0) begin
			report($sformatf("unexpected word %02h", data));
			return;
		end
		w = der_q.pop_front();
		if (data !== w.data)
			report($sformatf("out_byte %02h, expected %02h", data, w.data));
		if (rl !== w.run_last)
			report($sformatf("run_last %b, expected %b (byte %02h)", rl, w.run_last, w.data));
		if (kd !== w.key_done)
			report($sformatf("key_done %b, expected %b (byte %02h)", kd, w.key_done, w.data));
		if (w.key_done) keys++;
	endtask
endclass

module tb_rsa_public_key_der_encoder;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_WORDS = 260;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index    = '0;
	logic [EXP_VAL_W-1:0] cfg_data     = '0;
	logic                 in_valid     = 1'b0;
	logic                 in_ready;
	logic [7:0]           modulus_byte = '0;
	logic                 out_valid;
	logic                 out_ready    = 1'b0;
	logic [7:0]           out_byte;
	logic                 run_last;
	logic                 key_done;

	der_scoreboard sb;
	int            send_idle_pct = 35;
	int            recv_idle_pct = 69;
	int            words_sent    = 0;
	int            cycles        = 0;

	rsa_public_key_der_encoder DUT (.*);

	initial forever #5 clk = ~clk;

	// Stall the output channel at random
	always @(posedge clk) begin
		if (!arst_n) out_ready <= 1'b0;
		else out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Watch both handshakes
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) sb.note_word(modulus_byte);
			if (out_valid && out_ready) sb.check_word(out_byte, run_last, key_done);
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words outstanding", cycles, sb.pending());
			$display("** rsa_public_key_der_encoder: FAILED **");
			$finish;
		end
	end

	// Offer one modulus word after a random gap and hold it until taken
	task automatic send_word(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		modulus_byte <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		words_sent++;
	endtask

	// Drop valid and hold off until every expected word has come out
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [EXP_VAL_W-1:0] data);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, data);
	endtask

	// Put a value in the low bits and random junk above it
	function automatic logic [EXP_VAL_W-1:0] with_junk(input logic [EXP_VAL_W-1:0] val,
			input int w);
		logic [EXP_VAL_W-1:0] r, mask;
		r    = {$urandom, $urandom};
		mask = (64'd1 << w) - 64'd1;
		return (r & ~mask) | (val & mask);
	endfunction

	// Mostly short keys, now and then a zero or an oversized length
	function automatic int unsigned pick_mod_len();
		case ($urandom_range(9))
			0: return 0;
			1: return 1023;
			2: return MAX_MODULUS_BYTES;
			3: return $urandom_range(40, 13);
			default: return $urandom_range(12, 1);
		endcase
	endfunction

	// One key with random content; long keys are cut short by shrinking the length mid-key
	task automatic random_key();
		int unsigned n, cut;
		if ($urandom_range(3) == 0)
			write_reg(REG_MODULUS_LENGTH, with_junk(pick_mod_len(), MOD_REG_W));
		if ($urandom_range(3) == 0) write_reg(REG_EXPONENT_LENGTH, {$urandom, $urandom});
		if ($urandom_range(3) == 0) write_reg(REG_EXPONENT_VALUE, {$urandom, $urandom});
		if ($urandom_range(24) == 0) write_reg(REG_UNUSED, {$urandom, $urandom});
		n   = sb.mod_len_eff();
		cut = n;
		if (n > 40 || $urandom_range(9) == 0) cut = $urandom_range(n < 6 ? n : 6, 1);
		repeat (cut) send_word(8'($urandom_range(255)));
		if (cut < n) begin
			write_reg(REG_MODULUS_LENGTH, with_junk($urandom_range(cut), MOD_REG_W));
			if ($urandom_range(1)) write_reg(REG_EXPONENT_VALUE, {$urandom, $urandom});
			send_word(8'($urandom_range(255)));
		end
	endtask

	initial begin
		int base;
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, closed early by a shrunk length
		send_word(8'hA5);
		send_word(8'h5A);
		write_reg(REG_MODULUS_LENGTH, with_junk(3, MOD_REG_W));
		send_word(8'h3C);

		// single-word keys, with and without modulus pad
		write_reg(REG_UNUSED, {$urandom, $urandom});
		write_reg(REG_MODULUS_LENGTH, with_junk(1, MOD_REG_W));
		send_word(8'h00);
		send_word(8'hFF);

		// zero length acts as one; full-width exponent with pad
		write_reg(REG_MODULUS_LENGTH, with_junk(0, MOD_REG_W));
		write_reg(REG_EXPONENT_LENGTH, with_junk(MAX_EXPONENT_BYTES, EXP_REG_W));
		write_reg(REG_EXPONENT_VALUE, '1);
		send_word(8'h80);

		// oversized exponent length clamps to eight bytes
		write_reg(REG_EXPONENT_LENGTH, with_junk(15, EXP_REG_W));
		write_reg(REG_EXPONENT_VALUE, 64'h0123_4567_89AB_CDEF);
		write_reg(REG_MODULUS_LENGTH, with_junk(3, MOD_REG_W));
		send_word(8'h7F);
		send_word(8'h00);
		send_word(8'hFF);

		// zero exponent length acts as one, padded single byte
		write_reg(REG_EXPONENT_LENGTH, with_junk(0, EXP_REG_W));
		write_reg(REG_EXPONENT_VALUE, 64'h80);
		write_reg(REG_MODULUS_LENGTH, with_junk(2, MOD_REG_W));
		send_word(8'hC3);
		send_word(8'h01);

		write_reg(REG_EXPONENT_VALUE, '0);
		write_reg(REG_MODULUS_LENGTH, with_junk(4, MOD_REG_W));
		repeat (4) send_word(8'($urandom_range(255)));

		// oversized modulus length clamps, then shrink and change the exponent mid-key
		write_reg(REG_MODULUS_LENGTH, with_junk(1023, MOD_REG_W));
		send_word(8'h90);
		send_word(8'h11);
		send_word(8'h22);
		write_reg(REG_MODULUS_LENGTH, with_junk(2, MOD_REG_W));
		write_reg(REG_EXPONENT_LENGTH, with_junk(2, EXP_REG_W));
		write_reg(REG_EXPONENT_VALUE, 64'hFEDC_BA98_7654_FF00);
		send_word(8'h33);

		// largest exact length, closed after one word
		write_reg(REG_MODULUS_LENGTH, with_junk(MAX_MODULUS_BYTES, MOD_REG_W));
		send_word(8'h05);
		write_reg(REG_MODULUS_LENGTH, with_junk(1, MOD_REG_W));
		send_word(8'hAA);

		// random keys under three idle patterns
		base = words_sent;
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 35;
					recv_idle_pct = 69;
				end
				1: begin
					send_idle_pct = 69;
					recv_idle_pct = 35;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			while (words_sent < base + RANDOM_WORDS * (phase + 1) / 3) random_key();
		end

		wait_idle();
		repeat (20) @(posedge clk);
		$display("Sent %0d modulus words; checked %0d DER words over %0d complete keys.",
			sb.words_in, sb.words_out, sb.keys);
		$display("Lengths from zero to oversized, mid-key changes and three stall patterns ran.");
		if (sb.errors == 0) begin
			$display("** rsa_public_key_der_encoder: PASSED **");
		end else begin
			$display("%0d mismatches", sb.errors);
			$display("** rsa_public_key_der_encoder: FAILED **");
		end
		$finish;
	end
endmodule

[sim.f]
hdl/rpk_pkg.sv
hdl/rpk_front.sv
hdl/rpk_queue.sv
hdl/rpk_back.sv
hdl/rsa_public_key_der_encoder.sv
verif/tb_rsa_public_key_der_encoder.sv
